// ===== rtl/vbc_pkg.sv =====
// Shared types, widths and helpers for the Verlet bone-chain step block.
// No dependencies; every other file in rtl/ imports this package.
package vbc_pkg;

	localparam int NODE_W     = 8;
	localparam int POS_W      = 32;
	localparam int Q_W        = 16;
	localparam int LEN_W      = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int VEC_W      = 64;
	localparam int UNIT_W     = 32;
	localparam int QUO_W      = 31;
	localparam int MAG_LIM_B  = 31;
	localparam int VBC_NODES  = 256;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_SCL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z    = 3'd5;

	// request codes
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_INIT = 2'd1;
	localparam logic [1:0] REQ_STEP = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_INIT, S_READ, S_MUL, S_ACC, S_NORM, S_NWAIT, S_WRITE
	} vbc_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE
	} vbc_nstate_t;

	// micro-operations of the shared multiplier, in issue order
	typedef enum logic [5:0] {
		OP_DX_V, OP_DX_G, OP_DY_V, OP_DY_G, OP_DZ_V, OP_DZ_G,
		OP_UU_X, OP_UU_Y, OP_UU_Z, OP_WW,
		OP_UV_X, OP_UV_Y, OP_UV_Z,
		OP_CX_A, OP_CX_B, OP_CY_A, OP_CY_B, OP_CZ_A, OP_CZ_B,
		OP_RX_W, OP_RX_U, OP_RX_C, OP_RY_W, OP_RY_U, OP_RY_C,
		OP_RZ_W, OP_RZ_U, OP_RZ_C,
		OP_BX, OP_BY, OP_BZ,
		OP_TX, OP_TY, OP_TZ
	} vbc_op_t;

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -35'sd2147483648)
			return 32'sh80000000;
		else
			return $signed(v[POS_W-1:0]);
	endfunction

	function automatic logic signed [Q_W-1:0] sat16(input logic signed [29:0] v);
		if (v > 30'sd32767)
			return 16'sh7FFF;
		else if (v < -30'sd32768)
			return 16'sh8000;
		else
			return $signed(v[Q_W-1:0]);
	endfunction

endpackage

// ===== rtl/vbc_mul.sv =====
// Registered signed multiplier, instanced once by the sequencer and once by the normaliser.
// Depends on vbc_pkg for operand widths.
module vbc_mul (
	input  logic                               clk,
	input  logic signed [vbc_pkg::MUL_W-1:0]   a,
	input  logic signed [vbc_pkg::MUL_W-1:0]   b,
	output logic signed [vbc_pkg::PROD_W-1:0]  p
);
	import vbc_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== rtl/vbc_norm.sv =====
// Iterative vector normaliser: range shift, sum of squares, bit-serial root,
// three-lane restoring divide. Depends on vbc_pkg and vbc_mul.
module vbc_norm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [vbc_pkg::VEC_W-1:0]   vec  [3],
	output logic                               done,
	output logic signed [vbc_pkg::UNIT_W-1:0]  unit [3]
);
	import vbc_pkg::*;

	vbc_nstate_t              nstate_q, nstate_nx;
	logic [VEC_W-1:0]         mag_q [3];
	logic                     neg_q [3];
	logic [4:0]               cnt_q;
	logic [VEC_W-1:0]         x_q, res_q, bit_q;
	logic [UNIT_W-1:0]        rem_q [3];
	logic [QUO_W-1:0]         quo_q [3];

	logic                     big;
	logic signed [MUL_W-1:0]  sq_a;
	logic signed [PROD_W-1:0] sq_p;
	logic [VEC_W-1:0]         rt_t;
	logic                     rt_ge;
	logic [UNIT_W:0]          dv_t  [3];
	logic                     dv_ge [3];
	logic [UNIT_W-1:0]        len_w;

	vbc_mul u_sq (.clk(clk), .a(sq_a), .b(sq_a), .p(sq_p));

	assign big   = (|mag_q[0][VEC_W-1:MAG_LIM_B]) | (|mag_q[1][VEC_W-1:MAG_LIM_B])
		| (|mag_q[2][VEC_W-1:MAG_LIM_B]);
	assign len_w = res_q[UNIT_W-1:0];
	assign rt_t  = res_q + bit_q;
	assign rt_ge = (x_q >= rt_t);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_a = $signed(MUL_W'(mag_q[0][MAG_LIM_B-1:0]));
			2'd1:    sq_a = $signed(MUL_W'(mag_q[1][MAG_LIM_B-1:0]));
			2'd2:    sq_a = $signed(MUL_W'(mag_q[2][MAG_LIM_B-1:0]));
			default: sq_a = '0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_t[i]  = {rem_q[i], (cnt_q == 5'd0) ? mag_q[i][0] : 1'b0};
			dv_ge[i] = (dv_t[i] >= {1'b0, len_w});
		end
	end

	// next state
	always_comb begin
		nstate_nx = nstate_q;
		case (nstate_q)
			N_IDLE:  if (start) nstate_nx = N_SHIFT;
			N_SHIFT: if (!big) nstate_nx = N_SQ;
			N_SQ:    if (cnt_q == 5'd3) nstate_nx = N_SQRT;
			N_SQRT:  if (bit_q[0]) nstate_nx = N_DIV;
			N_DIV:   if (cnt_q == 5'(QUO_W - 1)) nstate_nx = N_DONE;
			N_DONE:  nstate_nx = N_IDLE;
			default: nstate_nx = N_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (nstate_q == N_DONE);
		for (int i = 0; i < 3; i++) begin
			if (len_w == '0)
				unit[i] = '0;
			else if (neg_q[i])
				unit[i] = -$signed({1'b0, quo_q[i]});
			else
				unit[i] = $signed({1'b0, quo_q[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nstate_q <= N_IDLE;
			cnt_q    <= '0;
		end else begin
			nstate_q <= nstate_nx;
			case (nstate_q)
				N_SQ:    cnt_q <= (cnt_q == 5'd3) ? 5'd0 : cnt_q + 5'd1;
				N_DIV:   cnt_q <= cnt_q + 5'd1;
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (nstate_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= vec[i][VEC_W-1] ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
						neg_q[i] <= vec[i][VEC_W-1];
					end
				end
			end
			N_SHIFT: begin
				if (big) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end
			end
			N_SQ: begin
				if (cnt_q == 5'd1)
					x_q <= VEC_W'(sq_p);
				else if (cnt_q != 5'd0)
					x_q <= x_q + VEC_W'(sq_p);
				res_q <= '0;
				bit_q <= VEC_W'(1) << 62;
			end
			N_SQRT: begin
				if (rt_ge) begin
					x_q   <= x_q - rt_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				for (int i = 0; i < 3; i++)
					rem_q[i] <= UNIT_W'(mag_q[i][MAG_LIM_B-1:1]);
			end
			N_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (dv_ge[i]) begin
						rem_q[i] <= UNIT_W'(dv_t[i] - {1'b0, len_w});
						quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b1};
					end else begin
						rem_q[i] <= dv_t[i][UNIT_W-1:0];
						quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b0};
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/verlet_bone_chain_step_top.sv =====
// Verlet bone-chain step: per-node tip memory, rest data memory, sequencer.
// Load and init transactions pass through a single state; a step makes 34
// passes through the shared 33x33 multiplier, each issued and then accumulated,
// plus three normaliser passes (range shift, sum of squares, bit-serial root
// and divide on each of the three vectors), plus any wait for the output register.
// One transaction at a time; a finished result waits in an output register.
// Reset (arst_n, asynchronous) restores the control and configuration registers and clears the parent.
module verlet_bone_chain_step_top #(
	parameter int NODE_COUNT = vbc_pkg::VBC_NODES
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [vbc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [vbc_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [1:0]                             req_type,
	input  logic [vbc_pkg::NODE_W-1:0]             node_index,
	input  logic                                   chain_start,
	input  logic signed [vbc_pkg::POS_W-1:0]       pos_x,
	input  logic signed [vbc_pkg::POS_W-1:0]       pos_y,
	input  logic signed [vbc_pkg::POS_W-1:0]       pos_z,
	input  logic signed [vbc_pkg::Q_W-1:0]         quat_w,
	input  logic signed [vbc_pkg::Q_W-1:0]         quat_x,
	input  logic signed [vbc_pkg::Q_W-1:0]         quat_y,
	input  logic signed [vbc_pkg::Q_W-1:0]         quat_z,
	input  logic [vbc_pkg::LEN_W-1:0]              bone_length,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [vbc_pkg::NODE_W-1:0]             node_out,
	output logic signed [vbc_pkg::POS_W-1:0]       tip_x,
	output logic signed [vbc_pkg::POS_W-1:0]       tip_y,
	output logic signed [vbc_pkg::POS_W-1:0]       tip_z
);
	import vbc_pkg::*;

	localparam int AW     = $clog2(NODE_COUNT);
	localparam int TIP_W  = 6 * POS_W;
	localparam int REST_W = 3 * Q_W + LEN_W;

	// configuration registers
	logic [16:0]              damping_q, stiffness_q;
	logic [19:0]              grav_scl_q;
	logic signed [Q_W-1:0]    gdir_q [3];

	// sequencer
	vbc_state_t               state_q, state_nx;
	vbc_op_t                  op_q;
	logic                     in_take, out_take;
	logic                     tip_we, rest_we, norm_start, write_go;

	// captured transaction
	logic [NODE_W-1:0]        node_q;
	logic [AW-1:0]            idx_q;
	logic signed [POS_W-1:0]  p_q   [3];
	logic signed [POS_W-1:0]  par_q [3];
	logic signed [Q_W-1:0]    q_q   [4];
	logic [LEN_W-1:0]         blen_q;
	logic signed [POS_W-1:0]  last_par_q [3];
	logic [NODE_W-1:0]        nrem;

	// memories and registered read data
	logic [TIP_W-1:0]         tip_mem  [NODE_COUNT];
	logic [REST_W-1:0]        rest_mem [NODE_COUNT];
	logic [TIP_W-1:0]         tip_rd_q, tip_wd;
	logic [REST_W-1:0]        rest_rd_q, rest_wd;
	logic signed [POS_W-1:0]  cur_rd [3], old_rd [3];
	logic signed [Q_W-1:0]    rest_rd [3];
	logic [LEN_W-1:0]         len_rd;

	// arithmetic state
	logic signed [PROD_W-1:0] acc_q;
	logic signed [MUL_W-1:0]  ww_q, uv_q;
	logic signed [MUL_W-1:0]  c_q [3];
	logic signed [VEC_W-1:0]  vec_q [3];
	logic signed [UNIT_W-1:0] du_q [3], ru_q [3];
	logic signed [POS_W-1:0]  tip_q [3];
	logic signed [POS_W-1:0]  tip_out_q [3];
	logic [NODE_W-1:0]        node_out_q;
	logic                     out_valid_q;

	// multiplier operands
	logic [16:0]              dmp, stf;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [MUL_W-1:0]  dmp_w, stf_w, gs_w, len_w;
	logic signed [MUL_W-1:0]  vel_w [3], gd_w [3], r_w [3], bd_w [3], dir_w [3];
	logic signed [MUL_W-1:0]  qm [4];

	logic                     norm_done;
	logic signed [UNIT_W-1:0] norm_unit [3];

	vbc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	vbc_norm u_norm (
		.clk(clk), .arst_n(arst_n), .start(norm_start), .vec(vec_q),
		.done(norm_done), .unit(norm_unit)
	);

	assign in_take  = in_valid & ~in_stall;
	assign out_take = out_valid_q & ~out_stall;
	assign write_go = (state_q == S_WRITE) & ~out_valid_q;

	// Fold the node index into the memory range: subtract shifted copies of
	// the node count, largest first.
	always_comb begin
		nrem = node_index;
		for (int k = NODE_W - 1; k >= 0; k--) begin
			if (int'(nrem) >= (NODE_COUNT << k))
				nrem = nrem - NODE_W'(NODE_COUNT << k);
		end
	end

	// damping and stiffness above one act as one
	assign dmp = (damping_q > ONE_Q16) ? 17'd0 : 17'(ONE_Q16 - damping_q);
	assign stf = (stiffness_q > ONE_Q16) ? ONE_Q16 : stiffness_q;

	// unpack read words and widen the operands for the shared multiplier
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur_rd[i]  = $signed(tip_rd_q[TIP_W-1-POS_W*i -: POS_W]);
			old_rd[i]  = $signed(tip_rd_q[3*POS_W-1-POS_W*i -: POS_W]);
			rest_rd[i] = $signed(rest_rd_q[REST_W-1-Q_W*i -: Q_W]);
			vel_w[i]   = MUL_W'(cur_rd[i]) - MUL_W'(old_rd[i]);
			gd_w[i]    = MUL_W'(gdir_q[i]);
			r_w[i]     = MUL_W'(rest_rd[i]);
			bd_w[i]    = MUL_W'(ru_q[i]) - MUL_W'(du_q[i]);
			dir_w[i]   = MUL_W'(du_q[i]);
		end
		for (int j = 0; j < 4; j++)
			qm[j] = MUL_W'(q_q[j]);
		len_rd = rest_rd_q[LEN_W-1:0];
		dmp_w  = $signed(MUL_W'(dmp));
		stf_w  = $signed(MUL_W'(stf));
		gs_w   = $signed(MUL_W'(grav_scl_q));
		len_w  = $signed(MUL_W'(len_rd));
	end

	// operand selection for the micro-operation being issued
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_DX_V: begin mul_a = vel_w[0]; mul_b = dmp_w;    end
			OP_DX_G: begin mul_a = gs_w;     mul_b = gd_w[0];  end
			OP_DY_V: begin mul_a = vel_w[1]; mul_b = dmp_w;    end
			OP_DY_G: begin mul_a = gs_w;     mul_b = gd_w[1];  end
			OP_DZ_V: begin mul_a = vel_w[2]; mul_b = dmp_w;    end
			OP_DZ_G: begin mul_a = gs_w;     mul_b = gd_w[2];  end
			OP_UU_X: begin mul_a = qm[1];    mul_b = qm[1];    end
			OP_UU_Y: begin mul_a = qm[2];    mul_b = qm[2];    end
			OP_UU_Z: begin mul_a = qm[3];    mul_b = qm[3];    end
			OP_WW:   begin mul_a = qm[0];    mul_b = qm[0];    end
			OP_UV_X: begin mul_a = qm[1];    mul_b = r_w[0];   end
			OP_UV_Y: begin mul_a = qm[2];    mul_b = r_w[1];   end
			OP_UV_Z: begin mul_a = qm[3];    mul_b = r_w[2];   end
			OP_CX_A: begin mul_a = qm[2];    mul_b = r_w[2];   end
			OP_CX_B: begin mul_a = qm[3];    mul_b = r_w[1];   end
			OP_CY_A: begin mul_a = qm[3];    mul_b = r_w[0];   end
			OP_CY_B: begin mul_a = qm[1];    mul_b = r_w[2];   end
			OP_CZ_A: begin mul_a = qm[1];    mul_b = r_w[1];   end
			OP_CZ_B: begin mul_a = qm[2];    mul_b = r_w[0];   end
			OP_RX_W: begin mul_a = ww_q;     mul_b = r_w[0];   end
			OP_RX_U: begin mul_a = uv_q;     mul_b = qm[1];    end
			OP_RX_C: begin mul_a = qm[0];    mul_b = c_q[0];   end
			OP_RY_W: begin mul_a = ww_q;     mul_b = r_w[1];   end
			OP_RY_U: begin mul_a = uv_q;     mul_b = qm[2];    end
			OP_RY_C: begin mul_a = qm[0];    mul_b = c_q[1];   end
			OP_RZ_W: begin mul_a = ww_q;     mul_b = r_w[2];   end
			OP_RZ_U: begin mul_a = uv_q;     mul_b = qm[3];    end
			OP_RZ_C: begin mul_a = qm[0];    mul_b = c_q[2];   end
			OP_BX:   begin mul_a = bd_w[0];  mul_b = stf_w;    end
			OP_BY:   begin mul_a = bd_w[1];  mul_b = stf_w;    end
			OP_BZ:   begin mul_a = bd_w[2];  mul_b = stf_w;    end
			OP_TX:   begin mul_a = dir_w[0]; mul_b = len_w;    end
			OP_TY:   begin mul_a = dir_w[1]; mul_b = len_w;    end
			OP_TZ:   begin mul_a = dir_w[2]; mul_b = len_w;    end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					case (req_type)
						REQ_LOAD: state_nx = S_LOAD;
						REQ_INIT: state_nx = S_INIT;
						REQ_STEP: state_nx = S_READ;
						default:  state_nx = S_IDLE;
					endcase
				end
			end
			S_LOAD:  state_nx = S_IDLE;
			S_INIT:  state_nx = S_IDLE;
			S_READ:  state_nx = S_MUL;
			S_MUL:   state_nx = S_ACC;
			S_ACC: begin
				case (op_q)
					OP_DZ_G, OP_RZ_C, OP_BZ: state_nx = S_NORM;
					OP_TZ:                   state_nx = S_WRITE;
					default:                 state_nx = S_MUL;
				endcase
			end
			S_NORM:  state_nx = S_NWAIT;
			S_NWAIT: if (norm_done) state_nx = S_MUL;
			S_WRITE: if (!out_valid_q) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall   = (state_q != S_IDLE);
		rest_we    = (state_q == S_LOAD);
		tip_we     = (state_q == S_INIT) | write_go;
		norm_start = (state_q == S_NORM);
	end

	// memory write words: init sets current and previous alike, a step
	// moves current into previous
	always_comb begin
		if (state_q == S_INIT)
			tip_wd = {p_q[0], p_q[1], p_q[2], p_q[0], p_q[1], p_q[2]};
		else
			tip_wd = {tip_q[0], tip_q[1], tip_q[2], cur_rd[0], cur_rd[1], cur_rd[2]};
		rest_wd = {sat16(30'(p_q[0] >>> 2)), sat16(30'(p_q[1] >>> 2)),
			sat16(30'(p_q[2] >>> 2)), blen_q};
	end

	always_ff @(posedge clk) begin
		if (tip_we)
			tip_mem[idx_q] <= tip_wd;
		if (rest_we)
			rest_mem[idx_q] <= rest_wd;
		tip_rd_q  <= tip_mem[idx_q];
		rest_rd_q <= rest_mem[idx_q];
	end

	// control state, configuration and the running parent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_DX_V;
			out_valid_q <= 1'b0;
			damping_q   <= 17'd6554;
			stiffness_q <= 17'd6554;
			grav_scl_q  <= '0;
			gdir_q[0]   <= '0;
			gdir_q[1]   <= -16'sd16384;
			gdir_q[2]   <= '0;
			for (int i = 0; i < 3; i++)
				last_par_q[i] <= '0;
		end else begin
			state_q <= state_nx;
			if (in_take)
				op_q <= OP_DX_V;
			else if (state_q == S_ACC && op_q != OP_TZ)
				op_q <= vbc_op_t'(op_q + 6'd1);
			if (write_go) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < 3; i++)
					last_par_q[i] <= tip_q[i];
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DAMPING:   damping_q   <= cfg_data[16:0];
					CFG_STIFFNESS: stiffness_q <= cfg_data[16:0];
					CFG_GRAV_SCL:  grav_scl_q  <= cfg_data;
					CFG_GRAV_X:    gdir_q[0]   <= $signed(cfg_data[Q_W-1:0]);
					CFG_GRAV_Y:    gdir_q[1]   <= $signed(cfg_data[Q_W-1:0]);
					CFG_GRAV_Z:    gdir_q[2]   <= $signed(cfg_data[Q_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	// payload: capture the transaction, then accumulate each product
	always_ff @(posedge clk) begin
		if (in_take) begin
			node_q <= node_index;
			idx_q  <= AW'(nrem);
			blen_q <= bone_length;
			p_q[0] <= pos_x;
			p_q[1] <= pos_y;
			p_q[2] <= pos_z;
			q_q[0] <= quat_w;
			q_q[1] <= quat_x;
			q_q[2] <= quat_y;
			q_q[3] <= quat_z;
			par_q[0] <= chain_start ? pos_x : last_par_q[0];
			par_q[1] <= chain_start ? pos_y : last_par_q[1];
			par_q[2] <= chain_start ? pos_z : last_par_q[2];
		end

		if (state_q == S_ACC) begin
			case (op_q)
				// predicted tip minus parent; floor shifts via >>>
				OP_DX_V: vec_q[0] <= VEC_W'(cur_rd[0]) + VEC_W'(prod >>> 16) - VEC_W'(par_q[0]);
				OP_DY_V: vec_q[1] <= VEC_W'(cur_rd[1]) + VEC_W'(prod >>> 16) - VEC_W'(par_q[1]);
				OP_DZ_V: vec_q[2] <= VEC_W'(cur_rd[2]) + VEC_W'(prod >>> 16) - VEC_W'(par_q[2]);
				OP_DX_G: vec_q[0] <= vec_q[0] + VEC_W'(prod >>> 14);
				OP_DY_G: vec_q[1] <= vec_q[1] + VEC_W'(prod >>> 14);
				OP_DZ_G: vec_q[2] <= vec_q[2] + VEC_W'(prod >>> 14);
				// quaternion terms
				OP_UU_X, OP_UV_X, OP_CX_A, OP_CY_A, OP_CZ_A,
				OP_RX_W, OP_RY_W, OP_RZ_W:
					acc_q <= prod;
				OP_UU_Y, OP_UU_Z, OP_UV_Y:
					acc_q <= acc_q + prod;
				OP_WW:   ww_q   <= MUL_W'(prod - acc_q);
				OP_UV_Z: uv_q   <= MUL_W'(acc_q + prod);
				OP_CX_B: c_q[0] <= MUL_W'(acc_q - prod);
				OP_CY_B: c_q[1] <= MUL_W'(acc_q - prod);
				OP_CZ_B: c_q[2] <= MUL_W'(acc_q - prod);
				OP_RX_U, OP_RY_U, OP_RZ_U:
					acc_q <= acc_q + (prod <<< 1);
				OP_RX_C: vec_q[0] <= VEC_W'(acc_q + (prod <<< 1));
				OP_RY_C: vec_q[1] <= VEC_W'(acc_q + (prod <<< 1));
				OP_RZ_C: vec_q[2] <= VEC_W'(acc_q + (prod <<< 1));
				// blend toward the rotated rest direction
				OP_BX:   vec_q[0] <= VEC_W'(du_q[0]) + VEC_W'(prod >>> 16);
				OP_BY:   vec_q[1] <= VEC_W'(du_q[1]) + VEC_W'(prod >>> 16);
				OP_BZ:   vec_q[2] <= VEC_W'(du_q[2]) + VEC_W'(prod >>> 16);
				// place the tip at bone length from the parent
				OP_TX:   tip_q[0] <= sat32(35'(par_q[0]) + 35'(prod >>> 30));
				OP_TY:   tip_q[1] <= sat32(35'(par_q[1]) + 35'(prod >>> 30));
				OP_TZ:   tip_q[2] <= sat32(35'(par_q[2]) + 35'(prod >>> 30));
				default: ;
			endcase
		end

		// op_q already points past the vector just normalised
		if (state_q == S_NWAIT && norm_done) begin
			case (op_q)
				OP_UU_X, OP_TX: du_q <= norm_unit;
				OP_BX:          ru_q <= norm_unit;
				default: ;
			endcase
		end

		if (write_go) begin
			node_out_q <= node_q;
			tip_out_q  <= tip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign node_out  = node_out_q;
	assign tip_x     = tip_out_q[0];
	assign tip_y     = tip_out_q[1];
	assign tip_z     = tip_out_q[2];

endmodule

// ===== tb/verlet_bone_chain_step_top_tb.sv =====
// Testbench for verlet_bone_chain_step_top: directed table then random chains of nodes.
// Predicts each step result with its own fixed-point model and checks the node and tip of every result.
// Depends on rtl/vbc_pkg.sv and rtl/verlet_bone_chain_step_top.sv.
module verlet_bone_chain_step_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import vbc_pkg::*;

	localparam int DRAIN_CYCLES = 450;      // longer than the slowest step
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int RAND_PER_PHASE = 100;

	typedef longint vec3_t [3];

	typedef struct {
		logic [1:0]  req;
		logic [7:0]  node;
		logic        start;
		int          px, py, pz;
		shortint     qw, qx, qy, qz;
		logic [30:0] blen;
		bit          known;   // expected tip typed into the table
		int          ex, ey, ez;
	} request_t;

	typedef struct {
		logic [7:0] node;
		int         x, y, z;
	} tip_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [7:0]  node_index = '0;
	logic        chain_start = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic [30:0] bone_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  node_out;
	logic signed [31:0] tip_x, tip_y, tip_z;

	verlet_bone_chain_step_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .node_index(node_index), .chain_start(chain_start),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.bone_length(bone_length),
		.out_valid(out_valid), .out_stall(out_stall),
		.node_out(node_out), .tip_x(tip_x), .tip_y(tip_y), .tip_z(tip_z)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor state: per-node tips, rest data and the chain parent
	// ---------------------------------------------------------------
	int          cur_tip [256][3];
	int          old_tip [256][3];
	shortint     rest_dir [256][3];
	logic [30:0] bone_len [256];
	bit          rest_loaded [256];
	bit          tip_placed [256];
	int          parent_tip [3];
	logic [16:0] damping_q;
	logic [16:0] stiffness_q;
	logic [19:0] grav_scale_q;
	shortint     grav_dir [3];

	tip_t pending_tips [$];
	int   failures = 0;
	int   cycles = 0;
	bit   quiet = 1'b0;     // no idling on either side while set

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	// unit vector in Q1.30; a zero vector stays zero
	function automatic vec3_t unit_q30(vec3_t v);
		longint unsigned m [3];
		longint unsigned ss, len;
		vec3_t u;
		for (int i = 0; i < 3; i++)
			m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
		while (m[0] >= (64'd1 << 31) || m[1] >= (64'd1 << 31) || m[2] >= (64'd1 << 31)) begin
			m[0] >>= 1; m[1] >>= 1; m[2] >>= 1;
		end
		ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = root_floor(ss);
		for (int i = 0; i < 3; i++) begin
			longint c;
			c = (len == 0) ? 0 : longint'((m[i] << 30) / len);
			u[i] = (v[i] < 0) ? -c : c;
		end
		return u;
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic void reset_model();
		foreach (rest_loaded[i]) begin
			rest_loaded[i] = 0;
			tip_placed[i] = 0;
		end
		parent_tip = '{0, 0, 0};
		damping_q = 17'd6554;
		stiffness_q = 17'd6554;
		grav_scale_q = '0;
		grav_dir = '{0, -16384, 0};
	endfunction

	function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_DAMPING:   damping_q = val[16:0];
			CFG_STIFFNESS: stiffness_q = val[16:0];
			CFG_GRAV_SCL:  grav_scale_q = val;
			CFG_GRAV_X:    grav_dir[0] = shortint'(val[15:0]);
			CFG_GRAV_Y:    grav_dir[1] = shortint'(val[15:0]);
			CFG_GRAV_Z:    grav_dir[2] = shortint'(val[15:0]);
			default: ;
		endcase
	endfunction

	// Apply one accepted request to the node store; return 1 with the new tip on a step.
	function automatic bit advance_chain(request_t r, output tip_t t);
		int n;
		longint p [3], par [3], q [4], rv [3];
		longint uu, ww, uv, cx, cy, cz, dmp, stf, g;
		vec3_t d, du, rot, ru, bl, dir;
		int tip [3];
		n = r.node;
		p = '{r.px, r.py, r.pz};
		q = '{r.qw, r.qx, r.qy, r.qz};
		t = '{default: 0};
		case (r.req)
			REQ_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					longint s;
					s = p[i] >>> 2;
					if (s > 32767) s = 32767;
					if (s < -32768) s = -32768;
					rest_dir[n][i] = shortint'(s);
				end
				bone_len[n] = r.blen;
				rest_loaded[n] = 1;
				return 0;
			end
			REQ_INIT: begin
				for (int i = 0; i < 3; i++) begin
					cur_tip[n][i] = int'(p[i]);
					old_tip[n][i] = int'(p[i]);
				end
				tip_placed[n] = 1;
				return 0;
			end
			REQ_STEP: ;
			default: return 0;
		endcase

		for (int i = 0; i < 3; i++) begin
			par[i] = r.start ? p[i] : longint'(parent_tip[i]);
			rv[i] = rest_dir[n][i];
		end
		dmp = (damping_q > ONE_Q16) ? 0 : 65536 - longint'(damping_q);
		stf = (stiffness_q > ONE_Q16) ? 65536 : longint'(stiffness_q);
		for (int i = 0; i < 3; i++) begin
			g = (longint'(grav_scale_q) * longint'(grav_dir[i])) >>> 14;
			d[i] = longint'(cur_tip[n][i])
				+ (((longint'(cur_tip[n][i]) - longint'(old_tip[n][i])) * dmp) >>> 16)
				+ g - par[i];
		end
		du = unit_q30(d);

		// rest direction rotated by q v q*, scale left for the normaliser
		uu = q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
		ww = q[0] * q[0] - uu;
		uv = q[1] * rv[0] + q[2] * rv[1] + q[3] * rv[2];
		cx = q[2] * rv[2] - q[3] * rv[1];
		cy = q[3] * rv[0] - q[1] * rv[2];
		cz = q[1] * rv[1] - q[2] * rv[0];
		rot[0] = ww * rv[0] + 2 * uv * q[1] + 2 * q[0] * cx;
		rot[1] = ww * rv[1] + 2 * uv * q[2] + 2 * q[0] * cy;
		rot[2] = ww * rv[2] + 2 * uv * q[3] + 2 * q[0] * cz;
		ru = unit_q30(rot);

		for (int i = 0; i < 3; i++)
			bl[i] = du[i] + (((ru[i] - du[i]) * stf) >>> 16);
		dir = unit_q30(bl);

		for (int i = 0; i < 3; i++) begin
			tip[i] = clamp32(par[i] + ((dir[i] * longint'(bone_len[n])) >>> 30));
			old_tip[n][i] = cur_tip[n][i];
			cur_tip[n][i] = tip[i];
			parent_tip[i] = tip[i];
		end
		t.node = r.node;
		t.x = tip[0]; t.y = tip[1]; t.z = tip[2];
		return 1;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	function automatic int draw_gap();
		if (quiet)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	// Hold a request until the block takes it, then predict its outcome.
	task automatic send_request(request_t r);
		int gap;
		tip_t t;
		gap = draw_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type <= r.req;
		node_index <= r.node;
		chain_start <= r.start;
		pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz;
		quat_w <= r.qw; quat_x <= r.qx; quat_y <= r.qy; quat_z <= r.qz;
		bone_length <= r.blen;
		in_valid <= 1'b1;
		@(posedge clk iff !in_stall);
		if (advance_chain(r, t)) begin
			// a typed-in expectation overrides the predictor for this row
			if (r.known) begin
				t.x = r.ex; t.y = r.ey; t.z = r.ez;
			end
			pending_tips = {pending_tips, t};
		end
	endtask

	// Drop valid, wait out all results and the block's own tail.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_tips.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		set_register(idx, val);
	endtask

	task automatic write_all(logic [CFG_DATA_W-1:0] dmp, logic [CFG_DATA_W-1:0] stf,
			logic [CFG_DATA_W-1:0] gs, logic [CFG_DATA_W-1:0] gx,
			logic [CFG_DATA_W-1:0] gy, logic [CFG_DATA_W-1:0] gz);
		write_register(CFG_DAMPING, dmp);
		write_register(CFG_STIFFNESS, stf);
		write_register(CFG_GRAV_SCL, gs);
		write_register(CFG_GRAV_X, gx);
		write_register(CFG_GRAV_Y, gy);
		write_register(CFG_GRAV_Z, gz);
	endtask

	function automatic request_t mk(logic [1:0] rq, logic [7:0] nd, logic st,
			int x, int y, int z, shortint w, shortint a, shortint b, shortint c,
			logic [30:0] bl);
		request_t r;
		r = '{default: 0};
		r.req = rq; r.node = nd; r.start = st;
		r.px = x; r.py = y; r.pz = z;
		r.qw = w; r.qx = a; r.qy = b; r.qz = c;
		r.blen = bl;
		return r;
	endfunction

	function automatic int rand_pos();
		if ($urandom_range(0, 1))
			return int'($urandom_range(0, 1 << 20)) - (1 << 19);
		return int'($urandom);
	endfunction

	function automatic shortint rand_quat();
		return shortint'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic [30:0] rand_len();
		if ($urandom_range(0, 9) < 7)
			return 31'($urandom_range(0, 8 << 16));
		return 31'($urandom);
	endfunction

	function automatic request_t rand_request(logic [1:0] rq, logic [7:0] nd, logic st);
		return mk(rq, nd, st, rand_pos(), rand_pos(), rand_pos(),
			rand_quat(), rand_quat(), rand_quat(), rand_quat(), rand_len());
	endfunction

	// Mostly well-formed chains (load, init, repeated steps); the rest is noise.
	task automatic random_traffic(int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 7) begin
				int links, rounds;
				logic [7:0] base;
				links = $urandom_range(1, 5);
				rounds = $urandom_range(1, 4);
				base = 8'($urandom);
				for (int k = 0; k < links; k++) begin
					logic [7:0] nd;
					nd = base + 8'(k);
					if (!rest_loaded[nd] || $urandom_range(0, 1)) begin
						send_request(rand_request(REQ_LOAD, nd, 1'b0));
						sent++;
					end
					if (!tip_placed[nd] || $urandom_range(0, 2) == 0) begin
						send_request(rand_request(REQ_INIT, nd, 1'b0));
						sent++;
					end
				end
				for (int rd = 0; rd < rounds; rd++)
					for (int k = 0; k < links; k++) begin
						request_t r;
						r = rand_request(REQ_STEP, base + 8'(k), 1'b0);
						r.start = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
						send_request(r);
						sent++;
					end
			end else begin
				request_t r;
				r = rand_request(2'($urandom), 8'($urandom), 1'($urandom));
				// a step on a node never written would read undefined store
				if (r.req == REQ_STEP && !(rest_loaded[r.node] && tip_placed[r.node]))
					r.req = 2'd3;
				send_request(r);
				if (r.req != 2'd3)
					sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Output side: random stall, then hold low until a transaction moves
	// ---------------------------------------------------------------
	initial begin
		int k;
		forever begin
			k = draw_gap();
			if (k > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (k - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk iff (out_valid && !out_stall));
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		tip_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tips.size() == 0) begin
				$display("%0t: result with none expected: node %0d tip %0d %0d %0d",
					$time, node_out, tip_x, tip_y, tip_z);
				failures++;
			end else begin
				e = pending_tips.pop_front();
				if (node_out !== e.node) begin
					$display("%0t: node_out expected %0d actual %0d", $time, e.node, node_out);
					failures++;
				end
				if (tip_x !== e.x) begin
					$display("%0t: tip_x expected %0d actual %0d", $time, e.x, tip_x);
					failures++;
				end
				if (tip_y !== e.y) begin
					$display("%0t: tip_y expected %0d actual %0d", $time, e.y, tip_y);
					failures++;
				end
				if (tip_z !== e.z) begin
					$display("%0t: tip_z expected %0d actual %0d", $time, e.z, tip_z);
					failures++;
				end
			end
		end
	end

	// Watchdog: abandon a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		request_t table_rows [$];
		request_t r;
		reset_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero length leaves the tip on the anchor
		table_rows = {table_rows, mk(REQ_LOAD, 8'd0, 0, 65536, 0, 0, 0, 0, 0, 0, 31'd0)};
		table_rows = {table_rows, mk(REQ_INIT, 8'd0, 0, 100, 200, 300, 0, 0, 0, 0, 31'd0)};
		r = mk(REQ_STEP, 8'd0, 1, 5 << 16, 6 << 16, 7 << 16, 16384, 0, 0, 0, 31'd0);
		r.known = 1; r.ex = 5 << 16; r.ey = 6 << 16; r.ez = 7 << 16;
		table_rows = {table_rows, r};
		// every vector zero: normalising gives zero, tip lands on the anchor
		table_rows = {table_rows, mk(REQ_LOAD, 8'd1, 0, 0, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF)};
		table_rows = {table_rows, mk(REQ_INIT, 8'd1, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0)};
		r = mk(REQ_STEP, 8'd1, 1, 0, 0, 0, 0, 0, 0, 0, 31'd0);
		r.known = 1;
		table_rows = {table_rows, r};
		// rest direction saturates, positions at the extremes
		table_rows = {table_rows, mk(REQ_LOAD, 8'd2, 0, 32'sh7FFFFFFF, 32'sh80000000, 0,
			0, 0, 0, 0, 31'h7FFFFFFF)};
		table_rows = {table_rows, mk(REQ_INIT, 8'd2, 0, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh7FFFFFFF, 0, 0, 0, 0, 31'd0)};
		table_rows = {table_rows, mk(REQ_STEP, 8'd2, 1, 32'sh7FFFFFFF, 32'sh80000000, 0,
			-16384, 16384, -16384, 16384, 31'd0)};
		table_rows = {table_rows, mk(REQ_STEP, 8'd2, 0, -1, -1, -1,
			16384, -16384, 16384, -16384, 31'h7FFFFFFF)};
		table_rows = {table_rows, mk(REQ_LOAD, 8'd255, 0, -65536, 65536, 32768,
			0, 0, 0, 0, 31'h10000)};
		table_rows = {table_rows, mk(REQ_INIT, 8'd255, 0, -1, -1, -1, 0, 0, 0, 0, 31'd0)};
		table_rows = {table_rows, mk(REQ_STEP, 8'd255, 0, 0, 0, 0, 0, 0, 0, 16384, 31'd0)};
		// unknown request: ignored
		table_rows = {table_rows, mk(2'd3, 8'hFF, 1, -1, -1, -1, -1, -1, -1, -1,
			31'h7FFFFFFF)};
		table_rows = {table_rows, mk(REQ_STEP, 8'd255, 1, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 0, 16384, 0, 0, 31'd0)};
		table_rows = {table_rows, mk(REQ_STEP, 8'd0, 0, 0, 0, 0, 0, 0, 16384, 0, 31'd0)};
		foreach (table_rows[i])
			send_request(table_rows[i]);
		random_traffic(RAND_PER_PHASE);
		settle();

		// no damping, full stiffness, strongest gravity one way
		write_all(20'd0, 20'd65536, 20'd655360, 20'hFC000, 20'h04000, 20'hFC000);
		quiet = 1'b1;
		random_traffic(RAND_PER_PHASE);
		settle();
		quiet = 1'b0;

		// full damping, no stiffness, strongest gravity the other way
		write_all(20'd65536, 20'd0, 20'd655360, 20'h04000, 20'hFC000, 20'h04000);
		random_traffic(RAND_PER_PHASE);
		settle();

		// damping and stiffness above one act as one; damping, stiffness, scale and x with all bits high
		write_all(20'h1FFFF, 20'h1FFFF, 20'hFFFFF, 20'hFFFFF, 20'h00000, 20'h07FFF);
		random_traffic(RAND_PER_PHASE);
		settle();

		// two random settings inside the documented ranges
		repeat (2) begin
			write_all(20'($urandom_range(0, 65536)), 20'($urandom_range(0, 65536)),
				20'($urandom_range(0, 655360)), 20'($urandom_range(0, 32768) - 16384),
				20'($urandom_range(0, 32768) - 16384), 20'($urandom_range(0, 32768) - 16384));
			random_traffic(RAND_PER_PHASE);
			settle();
		end

		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/vbc_pkg.sv
rtl/vbc_mul.sv
rtl/vbc_norm.sv
rtl/verlet_bone_chain_step_top.sv
tb/verlet_bone_chain_step_top_tb.sv
